[design/pts_pkg.sv]
// Package for the priority task scheduler: task states, commands, status codes,
// and the control/status structs between controller and datapath. No dependencies.
package pts_pkg;

   localparam int unsigned PID_W = 16;

   typedef enum logic [2:0] {
      ST_DEAD      = 3'd0,
      ST_READY     = 3'd1,
      ST_RUNNING   = 3'd2,
      ST_SLEEPING  = 3'd3,
      ST_SUSPENDED = 3'd4
   } task_st_type;

   typedef enum logic [2:0] {
      CMD_CREATE    = 3'd0,
      CMD_TERMINATE = 3'd1,
      CMD_SUSPEND   = 3'd2,
      CMD_RESUME    = 3'd3,
      CMD_SLEEP     = 3'd4,
      CMD_YIELD     = 3'd5,
      CMD_TICK      = 3'd6,
      CMD_BAD       = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_FULL     = 3'd1,
      STS_NOTFOUND = 3'd2,
      STS_NOSUSP   = 3'd3,
      STS_NOTSUSP  = 3'd4,
      STS_BADCMD   = 3'd5,
      STS_NOIDS    = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_FREE_SCAN,
      FSM_CREATE,
      FSM_FIND_SCAN,
      FSM_APPLY,
      FSM_TICK_SCAN,
      FSM_DISP_INIT,
      FSM_DISP_SCAN,
      FSM_DISP_DONE,
      FSM_RESULT
   } fsm_type;

   // controller -> datapath
   typedef struct packed {
      logic    scan_clr;     // reset scan index and search flags
      logic    scan_step;    // examine one slot and advance
      logic    do_create;    // write new task in found dead slot
      logic    do_apply;     // apply terminate/suspend/resume/sleep/yield
      logic    disp_clr;     // start dispatch scan
      logic    disp_step;    // examine one slot for dispatch
      logic    disp_done;    // commit dispatch pick
   } dp_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic       scan_last;    // current scan index is the last slot
      logic       found;        // search found a slot
      logic       cur_valid;
      logic       table_full;
      logic       ids_out;
      logic       need_disp;    // apply or tick step wants a dispatch
      status_type apply_sts;
   } dp_sts_type;

endpackage

[design/priority_task_scheduler_top.sv]
// Top level of the priority task scheduler: stream ports, result register,
// controller and datapath. Depends on pts_pkg, pts_ctrl, pts_dp.
//
// One command beat in, one result beat out. The task table is scanned one
// slot per cycle: create scans for a dead slot, suspend and resume scan for
// the id, tick counts sleepers down, and each dispatch scans every slot once
// from after the last pick. A bad command goes straight to its result. The
// next command is taken while the last result still waits in the output
// register.
module priority_task_scheduler_top #(
   parameter int unsigned TASK_SLOTS  = 16,
   parameter int unsigned LOWEST_PRIO = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] cmd, [18:3] target_pid, [22:19] priority_req, [38:23] ticks, zero pad
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [18:3] new_pid, [19] running_valid, [23:20] running_slot,
   // [39:24] running_pid
   output logic [39:0] rsp_tdata
);
   import pts_pkg::*;

   localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
   localparam int unsigned PRIO_W = $clog2(LOWEST_PRIO + 2);

   dp_ctl_type ctl;
   dp_sts_type sts;
   status_type st;
   logic       cmd_load, rsp_load, rsp_free;
   logic [PID_W-1:0]  new_pid, run_pid;
   logic              run_valid;
   logic [SLOT_W-1:0] run_slot;

   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;

   assign cmd_load = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   pts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (req_tvalid),
      .cmd_ready  (req_tready),
      .cmd        (cmd_type'(req_tdata[2:0])),
      .rsp_free   (rsp_free),
      .rsp_load   (rsp_load),
      .rsp_status (st),
      .ctl        (ctl),
      .sts        (sts)
   );

   pts_dp #(
      .TASK_SLOTS  (TASK_SLOTS),
      .LOWEST_PRIO (LOWEST_PRIO),
      .SLOT_W      (SLOT_W),
      .PRIO_W      (PRIO_W)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd_load      (cmd_load),
      .cmd           (cmd_type'(req_tdata[2:0])),
      .target_pid    (req_tdata[18:3]),
      .priority_req  (req_tdata[22:19]),
      .ticks         (req_tdata[38:23]),
      .ctl           (ctl),
      .sts           (sts),
      .new_pid       (new_pid),
      .running_valid (run_valid),
      .running_slot  (run_slot),
      .running_pid   (run_pid)
   );

   logic [3:0] slot4;
   assign slot4 = 4'(run_slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= {run_pid, slot4, run_valid, new_pid, st};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff)
      else $error("result beat dropped");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("result register overwritten");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd_load |=> !req_tready)
      else $error("command accepted while busy");
endmodule

[design/pts_ctrl.sv]
// Controller state machine of the priority task scheduler.
// Sequences slot scans in the datapath; depends on pts_pkg.
module pts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  pts_pkg::cmd_type   cmd,
   input  logic               rsp_free,     // result register empty or draining
   output logic               rsp_load,
   output pts_pkg::status_type rsp_status,
   output pts_pkg::dp_ctl_type ctl,
   input  pts_pkg::dp_sts_type sts
);
   import pts_pkg::*;

   fsm_type    state_ff, state_in;
   status_type sts_ff, sts_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sts_ff <= sts_in;
   end

   always_comb begin
      state_in  = state_ff;
      sts_in    = sts_ff;
      ctl       = '0;
      cmd_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               sts_in       = STS_OK;
               ctl.scan_clr = 1'b1;
               unique case (cmd) inside
                  CMD_CREATE: begin
                     state_in = FSM_FREE_SCAN;
                  end
                  CMD_SUSPEND, CMD_RESUME: begin
                     state_in = FSM_FIND_SCAN;
                  end
                  CMD_TERMINATE, CMD_SLEEP, CMD_YIELD: begin
                     state_in = FSM_APPLY;
                  end
                  CMD_TICK: begin
                     state_in = FSM_TICK_SCAN;
                  end
                  default: begin
                     sts_in   = STS_BADCMD;
                     state_in = FSM_RESULT;
                  end
               endcase
            end
         end
         FSM_FREE_SCAN: begin
            if (sts.table_full) begin
               sts_in   = STS_FULL;
               state_in = FSM_RESULT;
            end else if (sts.ids_out) begin
               sts_in   = STS_NOIDS;
               state_in = FSM_RESULT;
            end else begin
               ctl.scan_step = 1'b1;
               if (sts.scan_last) state_in = FSM_CREATE;
            end
         end
         FSM_CREATE: begin
            if (sts.found) begin
               ctl.do_create = 1'b1;
            end else begin
               sts_in = STS_FULL;
            end
            state_in = FSM_RESULT;
         end
         FSM_FIND_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_last) state_in = FSM_APPLY;
         end
         FSM_APPLY: begin
            ctl.do_apply = 1'b1;
            sts_in       = sts.apply_sts;
            if (sts.need_disp) begin
               ctl.disp_clr = 1'b1;
               state_in     = FSM_DISP_SCAN;
            end else begin
               state_in = FSM_RESULT;
            end
         end
         FSM_TICK_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_last) state_in = FSM_DISP_INIT;
         end
         FSM_DISP_INIT: begin
            if (sts.need_disp) begin
               ctl.disp_clr = 1'b1;
               state_in     = FSM_DISP_SCAN;
            end else begin
               state_in = FSM_RESULT;
            end
         end
         FSM_DISP_SCAN: begin
            ctl.disp_step = 1'b1;
            if (sts.scan_last) state_in = FSM_DISP_DONE;
         end
         FSM_DISP_DONE: begin
            ctl.disp_done = 1'b1;
            state_in      = FSM_RESULT;
         end
         FSM_RESULT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_status = sts_ff;

   a_load_from_result: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> state_ff == FSM_RESULT)
      else $error("result loaded outside result state");
   a_ready_idle_only: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> state_ff == FSM_IDLE)
      else $error("command taken while busy");
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.do_create, ctl.do_apply, ctl.disp_step, ctl.disp_done, ctl.scan_step}))
      else $error("conflicting datapath commands");
endmodule

[design/pts_dp.sv]
// Datapath of the priority task scheduler: task slot table, scan index,
// lookup and dispatch search registers. Depends on pts_pkg.
module pts_dp #(
   parameter int unsigned TASK_SLOTS  = 16,
   parameter int unsigned LOWEST_PRIO = 15,
   parameter int unsigned SLOT_W      = 4,
   parameter int unsigned PRIO_W      = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_load,
   input  pts_pkg::cmd_type         cmd,
   input  logic [pts_pkg::PID_W-1:0] target_pid,
   input  logic [3:0]               priority_req,
   input  logic [pts_pkg::PID_W-1:0] ticks,
   input  pts_pkg::dp_ctl_type      ctl,
   output pts_pkg::dp_sts_type      sts,
   output logic [pts_pkg::PID_W-1:0] new_pid,
   output logic                     running_valid,
   output logic [SLOT_W-1:0]        running_slot,
   output logic [pts_pkg::PID_W-1:0] running_pid
);
   import pts_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
   localparam int unsigned CNT_W = $clog2(TASK_SLOTS + 1);
   localparam int unsigned BEST_W = PRIO_W + 1;

   task_st_type       state_ff [TASK_SLOTS];
   task_st_type       saved_ff [TASK_SLOTS];
   logic [PRIO_W-1:0] prio_ff  [TASK_SLOTS];
   logic [PID_W-1:0]  sleep_ff [TASK_SLOTS];
   logic [PID_W-1:0]  id_ff    [TASK_SLOTS];

   logic [SLOT_W-1:0] ptr_ff, cur_ff, idx_ff, pos_ff, hit_ff, pick_ff;
   logic              curv_ff, found_ff, pfound_ff;
   logic [PID_W-1:0]  last_id_ff, new_pid_ff;
   logic [CNT_W-1:0]  live_ff;
   logic [BEST_W-1:0] best_ff;

   cmd_type           cmd_ff;
   logic [PID_W-1:0]  pid_ff, ticks_ff;
   logic [PRIO_W-1:0] pri_ff;

   logic [SLOT_W-1:0] pos_next;
   assign pos_next = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd_load) begin
         cmd_ff   <= cmd;
         pid_ff   <= target_pid;
         ticks_ff <= ticks;
         if (PRIO_W >= 4) begin
            pri_ff <= (PRIO_W'(priority_req) > PRIO_W'(LOWEST_PRIO)) ?
                      PRIO_W'(LOWEST_PRIO) : PRIO_W'(priority_req);
         end else begin
            pri_ff <= ({28'd0, priority_req} > 32'(LOWEST_PRIO)) ?
                      PRIO_W'(LOWEST_PRIO) : PRIO_W'(priority_req);
         end
      end
   end

   // current status / lookup of current command
   task_st_type hit_st;
   assign hit_st = state_ff[hit_ff];

   always_comb begin
      // idx_ff counts every scan, dispatch included, so each one takes all slots
      sts.scan_last  = idx_ff == LAST_SLOT;
      sts.found      = found_ff;
      sts.cur_valid  = curv_ff;
      sts.table_full = live_ff >= CNT_W'(TASK_SLOTS);
      sts.ids_out    = last_id_ff == '1;
      // a zero tick changes nothing, not even an idle dispatch
      sts.need_disp  = (cmd_ff == CMD_TICK) ? (!curv_ff && ticks_ff != '0) : 1'b1;
      sts.apply_sts  = STS_OK;
      unique case (cmd_ff) inside
         CMD_TERMINATE, CMD_SLEEP: begin
            if (!curv_ff) begin
               sts.apply_sts = STS_NOTFOUND;
               sts.need_disp = 1'b0;
            end
         end
         CMD_SUSPEND: begin
            if (!found_ff) begin
               sts.apply_sts = STS_NOTFOUND;
               sts.need_disp = 1'b0;
            end else if (hit_st == ST_DEAD || hit_st == ST_SUSPENDED) begin
               sts.apply_sts = STS_NOSUSP;
               sts.need_disp = 1'b0;
            end else begin
               sts.need_disp = hit_st == ST_RUNNING;
            end
         end
         CMD_RESUME: begin
            if (!found_ff) sts.apply_sts = STS_NOTFOUND;
            else if (hit_st != ST_SUSPENDED) sts.apply_sts = STS_NOTSUSP;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            state_ff[i] <= ST_DEAD;
            saved_ff[i] <= ST_DEAD;
            prio_ff[i]  <= '0;
            sleep_ff[i] <= '0;
            id_ff[i]    <= '0;
         end
         ptr_ff     <= '0;
         cur_ff     <= '0;
         curv_ff    <= 1'b0;
         last_id_ff <= '0;
         live_ff    <= '0;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         new_pid_ff <= '0;
      end else begin
         if (ctl.scan_clr) begin
            idx_ff     <= '0;
            found_ff   <= 1'b0;
            new_pid_ff <= '0;
         end
         if (ctl.scan_step) begin
            idx_ff <= idx_ff + 1'b1;
            unique case (cmd_ff)
               CMD_CREATE: begin
                  if (!found_ff && state_ff[idx_ff] == ST_DEAD) begin
                     found_ff <= 1'b1;
                     hit_ff   <= idx_ff;
                  end
               end
               CMD_TICK: begin
                  if (ticks_ff != '0) begin
                     if (state_ff[idx_ff] == ST_SLEEPING) begin
                        if (ticks_ff >= sleep_ff[idx_ff]) begin
                           state_ff[idx_ff] <= ST_READY;
                           sleep_ff[idx_ff] <= '0;
                        end else begin
                           sleep_ff[idx_ff] <= sleep_ff[idx_ff] - ticks_ff;
                        end
                     end else if (state_ff[idx_ff] == ST_SUSPENDED &&
                                  saved_ff[idx_ff] == ST_SLEEPING) begin
                        if (ticks_ff >= sleep_ff[idx_ff]) begin
                           saved_ff[idx_ff] <= ST_READY;
                           sleep_ff[idx_ff] <= '0;
                        end else begin
                           sleep_ff[idx_ff] <= sleep_ff[idx_ff] - ticks_ff;
                        end
                     end
                  end
               end
               default: begin
                  // id lookup: first match wins
                  if (!found_ff && pid_ff != '0 && id_ff[idx_ff] == pid_ff) begin
                     found_ff <= 1'b1;
                     hit_ff   <= idx_ff;
                  end
               end
            endcase
         end
         if (ctl.do_create) begin
            last_id_ff       <= last_id_ff + 1'b1;
            new_pid_ff       <= last_id_ff + 1'b1;
            id_ff[hit_ff]    <= last_id_ff + 1'b1;
            prio_ff[hit_ff]  <= pri_ff;
            state_ff[hit_ff] <= ST_READY;
            saved_ff[hit_ff] <= ST_DEAD;
            sleep_ff[hit_ff] <= '0;
            live_ff          <= live_ff + 1'b1;
         end
         if (ctl.do_apply) begin
            unique case (cmd_ff)
               CMD_TERMINATE: begin
                  if (curv_ff) begin
                     state_ff[cur_ff] <= ST_DEAD;
                     curv_ff          <= 1'b0;
                     if (live_ff != '0) live_ff <= live_ff - 1'b1;
                  end
               end
               CMD_SLEEP: begin
                  if (curv_ff) begin
                     state_ff[cur_ff] <= ST_SLEEPING;
                     sleep_ff[cur_ff] <= ticks_ff;
                     curv_ff          <= 1'b0;
                  end
               end
               CMD_SUSPEND: begin
                  if (found_ff && hit_st != ST_DEAD && hit_st != ST_SUSPENDED) begin
                     state_ff[hit_ff] <= ST_SUSPENDED;
                     if (hit_st == ST_RUNNING) begin
                        saved_ff[hit_ff] <= ST_READY;
                        curv_ff          <= 1'b0;
                     end else begin
                        saved_ff[hit_ff] <= hit_st;
                     end
                  end
               end
               CMD_RESUME: begin
                  // running task goes back to ready first; resumed slot differs
                  if (curv_ff) state_ff[cur_ff] <= ST_READY;
                  curv_ff <= 1'b0;
                  if (found_ff && hit_st == ST_SUSPENDED) begin
                     state_ff[hit_ff] <= saved_ff[hit_ff];
                     saved_ff[hit_ff] <= ST_SUSPENDED;
                  end
               end
               CMD_YIELD: begin
                  if (curv_ff) state_ff[cur_ff] <= ST_READY;
                  curv_ff <= 1'b0;
               end
               default: begin
               end
            endcase
         end
         if (ctl.disp_clr) begin
            idx_ff <= '0;
         end
         if (ctl.disp_step) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (ctl.disp_done) begin
            if (pfound_ff) begin
               ptr_ff            <= pick_ff;
               cur_ff            <= pick_ff;
               curv_ff           <= 1'b1;
               state_ff[pick_ff] <= ST_RUNNING;
            end else begin
               curv_ff <= 1'b0;
            end
         end
      end
   end

   // dispatch search: one slot a cycle starting after the scan pointer
   always_ff @(posedge clock) begin
      if (ctl.disp_clr) begin
         pos_ff    <= (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + 1'b1;
         best_ff   <= BEST_W'(LOWEST_PRIO) + 1'b1;
         pfound_ff <= 1'b0;
      end else if (ctl.disp_step) begin
         pos_ff <= pos_next;
         if (state_ff[pos_ff] == ST_READY && BEST_W'(prio_ff[pos_ff]) < best_ff) begin
            best_ff   <= BEST_W'(prio_ff[pos_ff]);
            pick_ff   <= pos_ff;
            pfound_ff <= 1'b1;
         end
      end
   end

   assign new_pid       = new_pid_ff;
   assign running_valid = curv_ff;
   assign running_slot  = curv_ff ? cur_ff : '0;
   assign running_pid   = curv_ff ? id_ff[cur_ff] : '0;

   a_cur_is_running: assert property (@(posedge clock) disable iff (reset)
      (curv_ff && !ctl.do_apply && !ctl.disp_done) |-> state_ff[cur_ff] == ST_RUNNING)
      else $error("current slot not in running state");
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_W'(TASK_SLOTS))
      else $error("live task count overflow");
   a_pick_ready: assert property (@(posedge clock) disable iff (reset)
      (ctl.disp_done && pfound_ff) |-> state_ff[pick_ff] == ST_READY)
      else $error("dispatch picked a task that is not ready");
endmodule

[bench/tb_priority_task_scheduler_top.sv]
// Testbench for priority_task_scheduler_top: drives command beats, predicts each
// result beat with a behavioral copy of the task table, and checks every field.
// Depends on pts_pkg and the scheduler RTL.
module tb_priority_task_scheduler_top;
   import pts_pkg::*;

   localparam int SLOTS = 16;
   localparam int LOW_PRIO = 15;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] new_pid;
      logic        run_valid;
      logic [3:0]  run_slot;
      logic [15:0] run_pid;
   } sched_result_type;

   class sched_scoreboard_type;
      task_st_type    state_q[SLOTS];
      task_st_type    saved_q[SLOTS];
      int unsigned    prio_q[SLOTS];
      int unsigned    sleep_q[SLOTS];
      int unsigned    id_q[SLOTS];
      int unsigned    scan_ptr, cur_slot, newest_id, live;
      bit             cur_valid;
      sched_result_type pending_q[$];
      int             errors;
      int             checked;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            state_q[i] = ST_DEAD; saved_q[i] = ST_DEAD;
            prio_q[i] = 0; sleep_q[i] = 0; id_q[i] = 0;
         end
         scan_ptr = 0; cur_slot = 0; newest_id = 0; live = 0; cur_valid = 0;
         errors = 0; checked = 0;
      endfunction

      function void pick_next();
         int unsigned best, pick, p;
         bit found;
         best = LOW_PRIO + 1; pick = 0; found = 0; p = scan_ptr;
         for (int i = 0; i < SLOTS; i++) begin
            p = (p + 1) % SLOTS;
            if (state_q[p] == ST_READY && prio_q[p] < best) begin
               best = prio_q[p]; pick = p; found = 1;
            end
         end
         if (!found) begin
            cur_valid = 0;
            return;
         end
         scan_ptr = pick; cur_slot = pick; cur_valid = 1;
         state_q[pick] = ST_RUNNING;
      endfunction

      function void release_cur();
         if (cur_valid) begin
            state_q[cur_slot] = ST_READY;
            cur_valid = 0;
         end
      endfunction

      function bit lookup(int unsigned pid, output int unsigned slot);
         slot = 0;
         if (pid == 0) return 0;
         for (int i = 0; i < SLOTS; i++)
            if (id_q[i] == pid) begin
               slot = i;
               return 1;
            end
         return 0;
      endfunction

      function void note_command(logic [39:0] beat);
         cmd_type      cmd;
         int unsigned  pid, pri, ticks, slot, i;
         status_type   sts;
         sched_result_type r;
         cmd = cmd_type'(beat[2:0]);
         pid = beat[18:3]; pri = beat[22:19]; ticks = beat[38:23];
         sts = STS_OK; r.new_pid = 0;
         case (cmd)
            CMD_CREATE: begin
               if (live >= SLOTS) sts = STS_FULL;
               else if (newest_id >= 16'hFFFF) sts = STS_NOIDS;
               else begin
                  for (i = 0; i < SLOTS; i++) if (state_q[i] == ST_DEAD) break;
                  if (i >= SLOTS) sts = STS_FULL;
                  else begin
                     newest_id++;
                     id_q[i] = newest_id;
                     prio_q[i] = pri > LOW_PRIO ? LOW_PRIO : pri;
                     state_q[i] = ST_READY; saved_q[i] = ST_DEAD; sleep_q[i] = 0;
                     live++;
                     r.new_pid = newest_id;
                  end
               end
            end
            CMD_TERMINATE: begin
               if (!cur_valid) sts = STS_NOTFOUND;
               else begin
                  state_q[cur_slot] = ST_DEAD; cur_valid = 0;
                  if (live > 0) live--;
                  pick_next();
               end
            end
            CMD_SUSPEND: begin
               if (!lookup(pid, slot)) sts = STS_NOTFOUND;
               else if (state_q[slot] == ST_DEAD || state_q[slot] == ST_SUSPENDED)
                  sts = STS_NOSUSP;
               else if (state_q[slot] == ST_RUNNING) begin
                  saved_q[slot] = ST_READY; state_q[slot] = ST_SUSPENDED;
                  cur_valid = 0;
                  pick_next();
               end else begin
                  saved_q[slot] = state_q[slot]; state_q[slot] = ST_SUSPENDED;
               end
            end
            CMD_RESUME: begin
               if (!lookup(pid, slot)) sts = STS_NOTFOUND;
               else if (state_q[slot] != ST_SUSPENDED) sts = STS_NOTSUSP;
               else begin
                  state_q[slot] = saved_q[slot]; saved_q[slot] = ST_SUSPENDED;
               end
               release_cur();
               pick_next();
            end
            CMD_SLEEP: begin
               if (!cur_valid) sts = STS_NOTFOUND;
               else begin
                  state_q[cur_slot] = ST_SLEEPING; sleep_q[cur_slot] = ticks;
                  cur_valid = 0;
                  pick_next();
               end
            end
            CMD_YIELD: begin
               release_cur();
               pick_next();
            end
            CMD_TICK: begin
               if (ticks != 0) begin
                  for (i = 0; i < SLOTS; i++) begin
                     if (state_q[i] == ST_SLEEPING) begin
                        if (ticks >= sleep_q[i]) begin
                           state_q[i] = ST_READY; sleep_q[i] = 0;
                        end else sleep_q[i] -= ticks;
                     end else if (state_q[i] == ST_SUSPENDED &&
                                  saved_q[i] == ST_SLEEPING) begin
                        if (ticks >= sleep_q[i]) begin
                           saved_q[i] = ST_READY; sleep_q[i] = 0;
                        end else sleep_q[i] -= ticks;
                     end
                  end
                  if (!cur_valid) pick_next();
               end
            end
            default: sts = STS_BADCMD;
         endcase
         r.status = sts;
         r.run_valid = cur_valid;
         r.run_slot = cur_valid ? cur_slot[3:0] : 4'd0;
         r.run_pid = cur_valid ? id_q[cur_slot][15:0] : 16'd0;
         pending_q.push_back(r);
      endfunction

      function void check_result(logic [39:0] beat);
         sched_result_type e;
         checked++;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, beat);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (beat[2:0] !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, beat[2:0]);
            errors++;
         end
         if (beat[18:3] !== e.new_pid) begin
            $display("%0t: new_pid exp %0d got %0d", $time, e.new_pid, beat[18:3]);
            errors++;
         end
         if (beat[19] !== e.run_valid) begin
            $display("%0t: running_valid exp %0d got %0d", $time, e.run_valid, beat[19]);
            errors++;
         end
         if (beat[23:20] !== e.run_slot) begin
            $display("%0t: running_slot exp %0d got %0d", $time, e.run_slot, beat[23:20]);
            errors++;
         end
         if (beat[39:24] !== e.run_pid) begin
            $display("%0t: running_pid exp %0d got %0d", $time, e.run_pid, beat[39:24]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;

   sched_scoreboard_type sb = new();
   bit          calm = 0;     // no idling at the end of the run
   int          sent = 0;

   priority_task_scheduler_top #(.TASK_SLOTS(SLOTS), .LOWEST_PRIO(LOW_PRIO)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_command(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // receiver stalls in bursts
   initial begin
      int n;
      @(posedge clock);
      while (1) begin
         if (!calm && !reset && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   // one command beat; at random a gap burst before it unless calm
   task automatic send_cmd(cmd_type cmd, logic [15:0] pid, logic [3:0] pri,
                           logic [15:0] ticks);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {1'b0, ticks, pri, pid, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // wait on the clock first so the last accepted beat is already in the scoreboard
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] some_pid();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'($urandom);
         2: return 16'hFFFF;
         default: return 16'($urandom_range(1, sb.newest_id + 1));
      endcase
   endfunction

   function automatic logic [15:0] some_ticks();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, 12));
      endcase
   endfunction

   initial begin
      cmd_type c;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty-table errors, fill the table, every command and edge
      send_cmd(CMD_TERMINATE, 0, 0, 0);
      send_cmd(CMD_SLEEP, 0, 0, 5);
      send_cmd(CMD_YIELD, 0, 0, 0);
      send_cmd(CMD_SUSPEND, 0, 0, 0);
      send_cmd(CMD_RESUME, 16'hFFFF, 0, 0);
      send_cmd(CMD_BAD, 16'hFFFF, 4'hF, 16'hFFFF);
      for (int i = 0; i < 17; i++) send_cmd(CMD_CREATE, 0, 4'(i), 0);  // 17th is full
      send_cmd(CMD_TICK, 0, 0, 0);              // zero tick, nothing runs: no change
      send_cmd(CMD_TICK, 0, 0, 1);              // dispatch from tick
      send_cmd(CMD_SLEEP, 0, 0, 0);             // zero sleep
      send_cmd(CMD_SUSPEND, 16'd2, 0, 0);       // suspend running task
      send_cmd(CMD_SUSPEND, 16'd2, 0, 0);       // already suspended
      send_cmd(CMD_RESUME, 16'd3, 0, 0);        // not suspended
      send_cmd(CMD_RESUME, 16'd2, 0, 0);
      send_cmd(CMD_TICK, 0, 0, 16'hFFFF);
      send_cmd(CMD_TERMINATE, 0, 0, 0);
      send_cmd(CMD_SUSPEND, 16'd1, 0, 0);       // suspend running task id 1, woken by the tick
      drain();   // hold off until every result is in
      for (int k = 0; k < 900; k++) begin
         if (k == 800) calm = 1;
         case ($urandom_range(0, 15)) inside
            0, 1, 2:  c = CMD_CREATE;
            3, 4:     c = CMD_TERMINATE;
            5, 6:     c = CMD_SUSPEND;
            7, 8:     c = CMD_RESUME;
            9, 10:    c = CMD_SLEEP;
            11:       c = CMD_YIELD;
            12, 13, 14: c = CMD_TICK;
            default:  c = CMD_BAD;
         endcase
         send_cmd(c, some_pid(), 4'($urandom), some_ticks());
         if (k == 400) drain();
      end
      drain();
      repeat (60) @(posedge clock);
      $display("Ran %0d command beats, %0d results checked; covered create up to a full",
               sent, sb.checked);
      $display("table, suspend/resume, sleep and tick countdown, and priority dispatch.");
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

[sim.f]
design/pts_pkg.sv
design/pts_ctrl.sv
design/pts_dp.sv
design/priority_task_scheduler_top.sv
bench/tb_priority_task_scheduler_top.sv
